>>> rtl/core/spss_pkg.sv
// Shared widths, register indexes and helpers for the segment pair support scorer.
package spss_pkg;

  // Fixed point layout of coordinates and slack.
  localparam int FRAC_BITS  = 8;
  localparam int COORD_W    = 24;
  localparam int SLACK_W    = 23;
  localparam int SCORE_W    = 25;
  localparam int TOL_W      = 16;

  // Configuration port.
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SCORE_MODE = CFG_IDX_W'(1);

  // Tolerance is rescaled from Q8.8 to the coordinate fraction.
  localparam int EPS_SHL = (FRAC_BITS >= 8) ? FRAC_BITS - 8 : 0;
  localparam int EPS_SHR = (FRAC_BITS >= 8) ? 0 : 8 - FRAC_BITS;
  localparam int EPS_W   = TOL_W + EPS_SHL;

  // Geometry widths.
  localparam int DIFF_W = COORD_W + 1;
  localparam int PROD_W = 2 * DIFF_W;
  localparam int SUM_W  = PROD_W + 1;
  localparam int MAG_W  = PROD_W;
  localparam int ROOT_W = PROD_W / 2;
  localparam int SQ_T_W = MAG_W + 2;
  localparam int QUO_W  = DIFF_W + 3;
  localparam int DV_C_W = ROOT_W + QUO_W;
  localparam int SW     = 32;
  localparam int SPAN_W = QUO_W + 2;

  // Quality weights in Q1.16.
  localparam int QR_FRAC = 16;
  localparam int QR_W    = QR_FRAC + 1;
  localparam int QN_W    = EPS_W + QR_FRAC;
  localparam int QC_W    = EPS_W + QR_W;
  localparam int RES_W   = SPAN_W + QR_W;
  localparam logic [QR_W-1:0] Q_ONE = QR_W'(1) << QR_FRAC;

  localparam logic [SCORE_W-1:0] SCORE_MAX = '1;

  // Saturate a scaled score to the output width.
  function automatic logic [SCORE_W-1:0] sat_score(input logic [SPAN_W:0] v);
    logic [SCORE_W-1:0] r;
    if (v > (SPAN_W+1)'(SCORE_MAX)) r = SCORE_MAX;
    else r = v[SCORE_W-1:0];
    return r;
  endfunction

  // Magnitude of a signed sum.
  function automatic logic [MAG_W-1:0] abs_mag(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] a;
    a = v[SUM_W-1] ? -v : v;
    return a[MAG_W-1:0];
  endfunction

endpackage

>>> rtl/core/segment_pair_support_score.sv
// Segment pair support scorer: fully pipelined upper and lower match scores.
//
// The block takes one request per cycle unless the output stalls, and returns
// one result per request, in order. The pipeline length is set by the pipelined
// square root of the model segment length (one root bit per stage), the four
// parallel projection dividers (one quotient bit per stage) and the four
// quality dividers (one weight bit per stage). The whole pipeline advances
// together; it holds when a finished result is stalled at the output, and
// any bubbles inside it keep their place. Configuration is taken at any time
// on its own port and must only change while idle.
module segment_pair_support_score import spss_pkg::*; (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [CFG_DATA_W-1:0]       cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic signed [COORD_W-1:0]   model_start_x_i,
  input  logic signed [COORD_W-1:0]   model_start_y_i,
  input  logic signed [COORD_W-1:0]   model_end_x_i,
  input  logic signed [COORD_W-1:0]   model_end_y_i,
  input  logic signed [COORD_W-1:0]   image_start_x_i,
  input  logic signed [COORD_W-1:0]   image_start_y_i,
  input  logic signed [COORD_W-1:0]   image_end_x_i,
  input  logic signed [COORD_W-1:0]   image_end_y_i,
  input  logic [SLACK_W-1:0]          slack_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [SCORE_W-1:0]          upper_score_o,
  output logic [SCORE_W-1:0]          lower_score_o,
  output logic                        matched_o
);

  typedef struct packed {
    logic [MAG_W-1:0]            rem;
    logic [ROOT_W-1:0]           root;
    logic [3:0][MAG_W-1:0]       num;
    logic [1:0]                  neg;
    logic [SLACK_W-1:0]          dl;
  } sq_t;

  typedef struct packed {
    logic [ROOT_W-1:0]           den;
    logic [3:0][MAG_W-1:0]       rem;
    logic [3:0][QUO_W-1:0]       quo;
    logic [1:0]                  neg;
    logic [SLACK_W-1:0]          dl;
    logic                        lzero;
  } dv_t;

  typedef struct packed {
    logic [SPAN_W-1:0]           span_u;
    logic [SPAN_W-1:0]           span_l;
    logic                        fail_u;
    logic                        fail_l;
    logic                        lzero;
  } sc_t;

  typedef struct packed {
    logic [3:0][QN_W-1:0]        rem;
    logic [3:0][QR_W-1:0]        r;
    sc_t                         sc;
  } qd_t;

  // Configuration registers.
  logic [TOL_W-1:0] tol_q;
  logic             mode_q;
  logic [EPS_W-1:0] eps;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q  <= TOL_W'(768);
      mode_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_TOLERANCE:  tol_q  <= cfg_data_i[TOL_W-1:0];
        REG_SCORE_MODE: mode_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign eps = (EPS_W'(tol_q) << EPS_SHL) >> EPS_SHR;

  // Global pipeline advance.
  logic en;
  logic out_valid_q;
  assign en         = !(out_valid_q && out_stall_i);
  assign in_stall_o = !en;

  // Valid bits.
  logic v1_q, v2_q, v3_q, p1_v_q, p2_v_q, m1_v_q, m2_v_q, m3_v_q, m4_v_q;
  logic sq_v_q [ROOT_W+1];
  logic dv_v_q [QUO_W+1];
  logic qd_v_q [QR_W+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      p1_v_q <= 1'b0;
      p2_v_q <= 1'b0;
      m1_v_q <= 1'b0;
      m2_v_q <= 1'b0;
      m3_v_q <= 1'b0;
      m4_v_q <= 1'b0;
      out_valid_q <= 1'b0;
      for (int j = 0; j <= ROOT_W; j++) sq_v_q[j] <= 1'b0;
      for (int j = 0; j <= QUO_W; j++) dv_v_q[j] <= 1'b0;
      for (int j = 0; j <= QR_W; j++) qd_v_q[j] <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      sq_v_q[0] <= v3_q;
      for (int j = 0; j < ROOT_W; j++) sq_v_q[j+1] <= sq_v_q[j];
      dv_v_q[0] <= sq_v_q[ROOT_W];
      for (int j = 0; j < QUO_W; j++) dv_v_q[j+1] <= dv_v_q[j];
      p1_v_q <= dv_v_q[QUO_W];
      p2_v_q <= p1_v_q;
      qd_v_q[0] <= p2_v_q;
      for (int j = 0; j < QR_W; j++) qd_v_q[j+1] <= qd_v_q[j];
      m1_v_q <= qd_v_q[QR_W];
      m2_v_q <= m1_v_q;
      m3_v_q <= m2_v_q;
      m4_v_q <= m3_v_q;
      out_valid_q <= m4_v_q;
    end
  end

  // Front end registers: differences, products, sums.
  logic signed [DIFF_W-1:0] dx_q, dy_q, rax_q, ray_q, rbx_q, rby_q;
  logic [SLACK_W-1:0]       dl1_q, dl2_q, dl3_q;
  logic signed [PROD_W-1:0] pxx_q, pyy_q;
  logic signed [PROD_W-1:0] pdxax_q, pdyay_q, pdxay_q, pdyax_q;
  logic signed [PROD_W-1:0] pdxbx_q, pdyby_q, pdxby_q, pdybx_q;
  logic [MAG_W-1:0]         n_q;
  logic signed [SUM_W-1:0]  dota_q, crsa_q, dotb_q, crsb_q;
  logic signed [SUM_W-1:0]  n_sum;

  assign n_sum = SUM_W'(pxx_q) + SUM_W'(pyy_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      // Segment direction and endpoint offsets from the first model vertex.
      dx_q  <= DIFF_W'(model_end_x_i) - DIFF_W'(model_start_x_i);
      dy_q  <= DIFF_W'(model_end_y_i) - DIFF_W'(model_start_y_i);
      rax_q <= DIFF_W'(image_start_x_i) - DIFF_W'(model_start_x_i);
      ray_q <= DIFF_W'(image_start_y_i) - DIFF_W'(model_start_y_i);
      rbx_q <= DIFF_W'(image_end_x_i) - DIFF_W'(model_start_x_i);
      rby_q <= DIFF_W'(image_end_y_i) - DIFF_W'(model_start_y_i);
      dl1_q <= slack_i;
      // Products for length, dot and cross terms.
      pxx_q   <= dx_q * dx_q;
      pyy_q   <= dy_q * dy_q;
      pdxax_q <= dx_q * rax_q;
      pdyay_q <= dy_q * ray_q;
      pdxay_q <= dx_q * ray_q;
      pdyax_q <= dy_q * rax_q;
      pdxbx_q <= dx_q * rbx_q;
      pdyby_q <= dy_q * rby_q;
      pdxby_q <= dx_q * rby_q;
      pdybx_q <= dy_q * rbx_q;
      dl2_q   <= dl1_q;
      // Sums.
      n_q    <= n_sum[MAG_W-1:0];
      dota_q <= SUM_W'(pdxax_q) + SUM_W'(pdyay_q);
      crsa_q <= SUM_W'(pdxay_q) - SUM_W'(pdyax_q);
      dotb_q <= SUM_W'(pdxbx_q) + SUM_W'(pdyby_q);
      crsb_q <= SUM_W'(pdxby_q) - SUM_W'(pdybx_q);
      dl3_q  <= dl2_q;
    end
  end

  // Square root pipeline, one root bit per stage.
  sq_t                 sq_q  [ROOT_W+1];
  sq_t                 sq_nx [ROOT_W];
  logic [SQ_T_W-1:0]   sq_trial [ROOT_W];

  always_comb begin
    for (int j = 0; j < ROOT_W; j++) begin
      sq_nx[j] = sq_q[j];
      sq_trial[j] = (SQ_T_W'(sq_q[j].root) << (ROOT_W - j))
                  + (SQ_T_W'(1) << (2 * (ROOT_W - 1 - j)));
      if (SQ_T_W'(sq_q[j].rem) >= sq_trial[j]) begin
        sq_nx[j].rem  = sq_q[j].rem - sq_trial[j][MAG_W-1:0];
        sq_nx[j].root = sq_q[j].root | (ROOT_W'(1) << (ROOT_W - 1 - j));
      end
    end
  end

  // Projection dividers, one quotient bit per stage, shared divisor.
  dv_t                 dv_q  [QUO_W+1];
  dv_t                 dv_nx [QUO_W];
  logic [DV_C_W-1:0]   dv_sh [QUO_W];

  always_comb begin
    for (int j = 0; j < QUO_W; j++) begin
      dv_nx[j] = dv_q[j];
      dv_sh[j] = DV_C_W'(dv_q[j].den) << (QUO_W - 1 - j);
      for (int i = 0; i < 4; i++) begin
        if (DV_C_W'(dv_q[j].rem[i]) >= dv_sh[j]) begin
          dv_nx[j].rem[i] = dv_q[j].rem[i] - dv_sh[j][MAG_W-1:0];
          dv_nx[j].quo[i] = dv_q[j].quo[i] | (QUO_W'(1) << (QUO_W - 1 - j));
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sq_q[0].rem  <= n_q;
      sq_q[0].root <= '0;
      sq_q[0].num  <= {abs_mag(crsb_q), abs_mag(dotb_q), abs_mag(crsa_q), abs_mag(dota_q)};
      sq_q[0].neg  <= {dotb_q[SUM_W-1], dota_q[SUM_W-1]};
      sq_q[0].dl   <= dl3_q;
      for (int j = 0; j < ROOT_W; j++) sq_q[j+1] <= sq_nx[j];
      dv_q[0].den   <= sq_q[ROOT_W].root;
      dv_q[0].rem   <= sq_q[ROOT_W].num;
      dv_q[0].quo   <= '0;
      dv_q[0].neg   <= sq_q[ROOT_W].neg;
      dv_q[0].dl    <= sq_q[ROOT_W].dl;
      dv_q[0].lzero <= (sq_q[ROOT_W].root == '0);
      for (int j = 0; j < QUO_W; j++) dv_q[j+1] <= dv_nx[j];
    end
  end

  // Post stages: signed projections, then bounds and residual errors.
  logic signed [SW-1:0] sa_q, sb_q, ea_q, eb_q, len_q;
  logic [SLACK_W-1:0]   dlp1_q, dlp2_q;
  logic                 lz1_q, lz2_q;
  logic signed [SW-1:0] lo_q, hi_q, blo_u_q, bhi_u_q, blo_l_q, bhi_l_q;
  logic signed [SW-1:0] e_q [4];
  logic signed [SW-1:0] epsw, dlw1, dlw2;

  assign epsw = SW'(eps);
  assign dlw1 = SW'(dlp1_q);
  assign dlw2 = SW'(dlp2_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      sa_q   <= dv_q[QUO_W].neg[0] ? -SW'(dv_q[QUO_W].quo[0]) : SW'(dv_q[QUO_W].quo[0]);
      ea_q   <= SW'(dv_q[QUO_W].quo[1]);
      sb_q   <= dv_q[QUO_W].neg[1] ? -SW'(dv_q[QUO_W].quo[2]) : SW'(dv_q[QUO_W].quo[2]);
      eb_q   <= SW'(dv_q[QUO_W].quo[3]);
      len_q  <= SW'(dv_q[QUO_W].den);
      dlp1_q <= dv_q[QUO_W].dl;
      lz1_q  <= dv_q[QUO_W].lzero;
      lo_q    <= (sa_q < sb_q) ? sa_q : sb_q;
      hi_q    <= (sa_q < sb_q) ? sb_q : sa_q;
      e_q[0]  <= ea_q - dlw1;
      e_q[1]  <= eb_q - dlw1;
      e_q[2]  <= ea_q;
      e_q[3]  <= eb_q;
      blo_u_q <= -(epsw + dlw1);
      bhi_u_q <= len_q + epsw + dlw1;
      blo_l_q <= -epsw;
      bhi_l_q <= len_q + epsw;
      dlp2_q  <= dlp1_q;
      lz2_q   <= lz1_q;
    end
  end

  // Clip errors at zero, test them against the tolerance, clamp for the divider.
  logic signed [SW-1:0] ec   [4];
  logic                 over [4];
  logic [EPS_W-1:0]     errn [4];
  logic signed [SW-1:0] span_u_w, span_l_w;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      ec[i]   = e_q[i][SW-1] ? '0 : e_q[i];
      over[i] = ec[i] > epsw;
      errn[i] = over[i] ? eps : ec[i][EPS_W-1:0];
    end
    span_u_w = hi_q - lo_q + (dlw2 <<< 1);
    span_l_w = hi_q - lo_q;
  end

  // Quality dividers: err * 2^16 / eps, one weight bit per stage.
  qd_t               qd_q  [QR_W+1];
  qd_t               qd_nx [QR_W];
  logic [QC_W-1:0]   qd_sh [QR_W];

  always_comb begin
    for (int j = 0; j < QR_W; j++) begin
      qd_nx[j] = qd_q[j];
      qd_sh[j] = QC_W'(eps) << (QR_W - 1 - j);
      for (int i = 0; i < 4; i++) begin
        if (QC_W'(qd_q[j].rem[i]) >= qd_sh[j]) begin
          qd_nx[j].rem[i] = qd_q[j].rem[i] - qd_sh[j][QN_W-1:0];
          qd_nx[j].r[i]   = qd_q[j].r[i] | (QR_W'(1) << (QR_W - 1 - j));
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        qd_q[0].rem[i] <= {errn[i], QR_FRAC'(0)};
        qd_q[0].r[i]   <= '0;
      end
      qd_q[0].sc.fail_u <= (lo_q < blo_u_q) || (hi_q > bhi_u_q) || over[0] || over[1];
      qd_q[0].sc.fail_l <= (lo_q < blo_l_q) || (hi_q > bhi_l_q) || over[2] || over[3];
      qd_q[0].sc.span_u <= span_u_w[SPAN_W-1:0];
      qd_q[0].sc.span_l <= span_l_w[SPAN_W-1:0];
      qd_q[0].sc.lzero  <= lz2_q;
      for (int j = 0; j < QR_W; j++) qd_q[j+1] <= qd_nx[j];
    end
  end

  // Weight arithmetic: square, complement, product, scale.
  logic [2*QR_W-1:0]   rr_q [4];
  logic [QR_W-1:0]     qw_q [4];
  logic [2*QR_W-1:0]   tu_q, tl_q;
  logic [RES_W-1:0]    ru_q, rl_q;
  sc_t                 sc1_q, sc2_q, sc3_q, sc4_q;
  logic [SPAN_W:0]     cand_u, cand_l;
  logic [SCORE_W-1:0]  up_q, lo_sc_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 4; i++) rr_q[i] <= qd_q[QR_W].r[i] * qd_q[QR_W].r[i];
      sc1_q <= qd_q[QR_W].sc;
      for (int i = 0; i < 4; i++) begin
        qw_q[i] <= (eps == '0) ? Q_ONE : Q_ONE - rr_q[i][QR_FRAC +: QR_W];
      end
      sc2_q <= sc1_q;
      tu_q  <= qw_q[0] * qw_q[1];
      tl_q  <= qw_q[2] * qw_q[3];
      sc3_q <= sc2_q;
      ru_q  <= sc3_q.span_u * tu_q[QR_FRAC +: QR_W];
      rl_q  <= sc3_q.span_l * tl_q[QR_FRAC +: QR_W];
      sc4_q <= sc3_q;
      up_q    <= (sc4_q.fail_u || sc4_q.lzero) ? '0 : sat_score(cand_u);
      lo_sc_q <= (sc4_q.fail_l || sc4_q.lzero) ? '0 : sat_score(cand_l);
    end
  end

  // Plain mode takes the covered length, quadratic mode the weighted one.
  assign cand_u = mode_q ? ru_q[RES_W-1:QR_FRAC] : (SPAN_W+1)'(sc4_q.span_u);
  assign cand_l = mode_q ? rl_q[RES_W-1:QR_FRAC] : (SPAN_W+1)'(sc4_q.span_l);

  assign out_valid_o   = out_valid_q;
  assign upper_score_o = up_q;
  assign lower_score_o = lo_sc_q;
  assign matched_o     = (up_q != '0);

`ifndef SYNTHESIS
  // Slack only loosens the test, so the upper score never falls below the lower.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> upper_score_o >= lower_score_o)
    else $error("upper score below lower score");

  // The root remainder stays within 2*root at the end of the square root.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_v_q[ROOT_W] |-> sq_q[ROOT_W].rem <= MAG_W'({sq_q[ROOT_W].root, 1'b0}))
    else $error("square root remainder out of range");

  // Every projection remainder is below the segment length when that length is nonzero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dv_v_q[QUO_W] && !dv_q[QUO_W].lzero) |->
      (dv_q[QUO_W].rem[0] < MAG_W'(dv_q[QUO_W].den)) &&
      (dv_q[QUO_W].rem[1] < MAG_W'(dv_q[QUO_W].den)) &&
      (dv_q[QUO_W].rem[2] < MAG_W'(dv_q[QUO_W].den)) &&
      (dv_q[QUO_W].rem[3] < MAG_W'(dv_q[QUO_W].den)))
    else $error("projection divider remainder out of range");

  // Clamped errors keep every weight ratio at or below one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (qd_v_q[QR_W] && eps != '0) |->
      (qd_q[QR_W].r[0] <= Q_ONE) && (qd_q[QR_W].r[1] <= Q_ONE) &&
      (qd_q[QR_W].r[2] <= Q_ONE) && (qd_q[QR_W].r[3] <= Q_ONE))
    else $error("quality ratio above one");
`endif

endmodule
